@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker of the tag tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define CIT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tag tracker check failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define CIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tag tracker check failed");

`endif

@@ hdl/cit_pkg.sv @@
// Types and constants shared by the command issue tag tracker.
package cit_pkg;

    localparam int COOKIE_W = 8;
    localparam int COUNT_W  = 8;

    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_RETURN  = 1'b1;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_POINTER = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_BARRIER = 2'd3;

    localparam logic [COUNT_W-1:0] DRAIN_LIMIT = 8'd255;

    typedef struct packed {
        logic                action;
        logic [1:0]          kind;
        logic                want_cookie;
        logic [COOKIE_W-1:0] resp_cookie;
    } t_trk_req;

    typedef struct packed {
        logic                emit;
        logic [COOKIE_W-1:0] cookie;
        logic [COUNT_W-1:0]  count_after;
    } t_trk_rsp;

endpackage

@@ hdl/command_issue_tag_tracker_unit.sv @@
// Top level of the command issue tag tracker.
//
// Input channel (i_in_valid / o_in_stall): one item per cycle, either a
// command (i_action = 0) or a returned cookie (i_action = 1).
// Output channel (o_out_valid / i_out_stall): one result per command that
// arrives while the block is not draining; returns never give a result.
// An item is registered on entry and executed against the tracker state
// from the entry register once the result register can take it; its
// result is registered in the result register and offered from there.
// One item per clock is sustained unless the receiver stalls: an item's map
// bit is read on entry and written on execution, with a back-to-back bypass.
// Commands that arrive while draining are taken and dropped with no result;
// returns clear pending cookies until the count is back to zero.
// When the receiver stalls, the result register holds its item and the
// entry register still takes one more item; o_in_stall rises only when both
// are full or while the pending map is cleared after reset.
// Synchronous reset clears the pending count, the drain flag and both valid
// flags, then the pending map is cleared one slot per cycle: o_in_stall stays
// high until all min(COOKIE_SLOTS, 256) map slots are clear, 256 by default.
module command_issue_tag_tracker_unit #(
    parameter int COOKIE_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [1:0]  i_kind,
    input  logic [13:0] i_target,
    input  logic [15:0] i_command_tag,
    input  logic [31:0] i_scalar_arg,
    input  logic [63:0] i_pointer_arg,
    input  logic [7:0]  i_resp_cookie,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [13:0] o_target_out,
    output logic [15:0] o_tag_out,
    output logic [63:0] o_payload,
    output logic [7:0]  o_pending_after
);

    logic        r_s1_valid;
    logic        r_s1_action;
    logic [1:0]  r_s1_kind;
    logic [13:0] r_s1_target;
    logic [15:0] r_s1_tag;
    logic [31:0] r_s1_scalar;
    logic [63:0] r_s1_pointer;
    logic [7:0]  r_s1_cookie;

    logic        r_out_valid;
    logic [13:0] r_target;
    logic [15:0] r_tag;
    logic [63:0] r_payload;
    logic [7:0]  r_pending;
    logic [63:0] n_payload;

    logic              advance;
    logic              in_take;
    logic              fire;
    logic              clr_busy;
    cit_pkg::t_trk_req trk_req;
    cit_pkg::t_trk_rsp trk_rsp;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = clr_busy || (r_s1_valid && !advance);
    assign in_take    = i_in_valid && !o_in_stall;
    assign fire       = r_s1_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || advance) begin
            r_s1_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_action  <= i_action;
            r_s1_kind    <= i_kind;
            r_s1_target  <= i_target;
            r_s1_tag     <= i_command_tag;
            r_s1_scalar  <= i_scalar_arg;
            r_s1_pointer <= i_pointer_arg;
            r_s1_cookie  <= i_resp_cookie;
        end
    end

    assign trk_req.action      = r_s1_action;
    assign trk_req.kind        = r_s1_kind;
    assign trk_req.want_cookie = r_s1_scalar[0];
    assign trk_req.resp_cookie = r_s1_cookie;

    cit_track #(
        .COOKIE_SLOTS (COOKIE_SLOTS)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (in_take),
        .i_take_cookie (i_resp_cookie),
        .i_fire        (fire),
        .i_req         (trk_req),
        .o_rsp         (trk_rsp),
        .o_busy        (clr_busy)
    );

    always_comb begin
        case (r_s1_kind)
            cit_pkg::KIND_SCALAR:  n_payload = {32'd0, r_s1_scalar};
            cit_pkg::KIND_POINTER: n_payload = r_s1_pointer;
            default:               n_payload = {56'd0, trk_rsp.cookie};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && trk_rsp.emit;
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (fire && trk_rsp.emit) begin
            r_target  <= r_s1_target;
            r_tag     <= r_s1_tag;
            r_payload <= n_payload;
            r_pending <= trk_rsp.count_after;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_target_out    = r_target;
    assign o_tag_out       = r_tag;
    assign o_payload       = r_payload;
    assign o_pending_after = r_pending;

endmodule

@@ hdl/cit_track.sv @@
// Cookie tracker: pending count, pending map and drain state.
module cit_track #(
    parameter int COOKIE_SLOTS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [cit_pkg::COOKIE_W-1:0] i_take_cookie,
    input  logic                         i_fire,
    input  cit_pkg::t_trk_req            i_req,
    output cit_pkg::t_trk_rsp            o_rsp,
    output logic                         o_busy
);

    localparam int NUM_COOKIES = 1 << cit_pkg::COOKIE_W;
    localparam int MAP_DEPTH   = (COOKIE_SLOTS < NUM_COOKIES) ? COOKIE_SLOTS : NUM_COOKIES;
    localparam int IDX_W       = $clog2(MAP_DEPTH);

    logic [cit_pkg::COUNT_W-1:0]  r_count;
    logic [cit_pkg::COUNT_W-1:0]  n_count;
    logic                         r_draining;
    logic                         n_draining;
    logic                         r_map [MAP_DEPTH];
    logic                         r_map_rd;
    logic                         r_fwd;
    logic                         r_fwd_val;
    logic                         r_clr_busy;
    logic [IDX_W-1:0]             r_clr_idx;

    logic [IDX_W-1:0]             slot_tbl [NUM_COOKIES];
    logic [cit_pkg::COUNT_W-1:0]  count_inc;
    logic [cit_pkg::COOKIE_W-1:0] cookie_sel;
    logic [IDX_W-1:0]             slot;
    logic [IDX_W-1:0]             take_slot;
    logic                         is_return;
    logic                         is_read;
    logic                         map_we;
    logic                         map_val;
    logic                         map_hit;

    // Cookie to slot, worked out at elaboration
    for (genvar g = 0; g < NUM_COOKIES; g++) begin : g_slot
        assign slot_tbl[g] = IDX_W'(g % COOKIE_SLOTS);
    end

    assign is_return  = (i_req.action == cit_pkg::ACT_RETURN);
    assign is_read    = (i_req.kind == cit_pkg::KIND_READ)
                        || (i_req.kind == cit_pkg::KIND_BARRIER);
    assign count_inc  = r_count + cit_pkg::COUNT_W'(1);
    assign cookie_sel = is_return ? i_req.resp_cookie : count_inc;
    assign slot       = slot_tbl[cookie_sel];
    assign take_slot  = slot_tbl[i_take_cookie];
    // Map bit read as the item entered, bypassed by the write of the item ahead
    assign map_hit    = r_fwd ? r_fwd_val : r_map_rd;
    assign o_busy     = r_clr_busy;

    always_comb begin
        n_count          = r_count;
        n_draining       = r_draining;
        map_we           = 1'b0;
        map_val          = 1'b0;
        o_rsp.emit       = 1'b0;
        o_rsp.cookie     = '0;
        o_rsp.count_after = r_count;
        if (is_return) begin
            // While draining, clear a pending cookie; leave the drain once nothing is left
            if (r_draining && (i_req.resp_cookie != '0) && map_hit) begin
                map_we  = 1'b1;
                n_count = r_count - cit_pkg::COUNT_W'(1);
                if (n_count == '0) begin
                    n_draining = 1'b0;
                end
            end
        end else if (!r_draining) begin
            o_rsp.emit = 1'b1;
            if (is_read && i_req.want_cookie) begin
                n_count      = count_inc;
                o_rsp.cookie = count_inc;
                map_we       = (count_inc != '0);
                map_val      = 1'b1;
            end
            o_rsp.count_after = n_count;
            if (((i_req.kind == cit_pkg::KIND_BARRIER) || (n_count == cit_pkg::DRAIN_LIMIT))
                && (n_count != '0)) begin
                n_draining = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_draining <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            // Walk the map once after reset, one slot per cycle
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(MAP_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_fire) begin
                r_count    <= n_count;
                r_draining <= n_draining;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_map[r_clr_idx] <= 1'b0;
        end else if (i_fire && map_we) begin
            r_map[slot] <= map_val;
        end
        if (i_take) begin
            r_map_rd  <= r_map[take_slot];
            r_fwd     <= i_fire && map_we && (slot == take_slot);
            r_fwd_val <= map_val;
        end
    end

endmodule

@@ hdl/cit_checker.sv @@
// Port-level checker for the command issue tag tracker, with its bind.
`include "assert_macros.svh"

module cit_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_action,
    input logic [1:0]  i_kind,
    input logic [31:0] i_scalar_arg,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_payload
);

    logic        in_take;
    logic        out_free;
    logic        take_ret;
    logic        take_scalar;
    logic        scalar_match;
    logic [31:0] r_sc_d1;
    logic [31:0] r_sc_d2;

    assign in_take      = i_in_valid && !o_in_stall;
    assign out_free     = !o_out_valid || !i_out_stall;
    assign take_ret     = in_take && (i_action == cit_pkg::ACT_RETURN);
    assign take_scalar  = in_take && (i_action == cit_pkg::ACT_COMMAND)
                          && (i_kind == cit_pkg::KIND_SCALAR);
    assign scalar_match = (o_payload == {32'd0, r_sc_d2});

    // Delay the scalar argument to line up with its result
    always_ff @(posedge i_clk) begin
        r_sc_d1 <= i_scalar_arg;
        r_sc_d2 <= r_sc_d1;
    end

    `CIT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_payload))

    `CIT_ASSERT_IMPL(a_stall_needs_full, o_in_stall && o_out_valid, i_out_stall)

    // A returned cookie never shows up as a result
    `CIT_ASSERT_NEXT(a_return_silent, take_ret ##1 out_free, !o_out_valid)

    // A scalar command carries its argument through unchanged
    `CIT_ASSERT_NEXT(a_scalar_payload, take_scalar ##1 out_free, !o_out_valid || scalar_match)

endmodule

bind command_issue_tag_tracker_unit cit_checker u_cit_checker (.*);
